>>> rtl/handle_slot_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the handle slot allocator
// Each macro expands to one labeled concurrent assertion with a reset disable.
// ----------------------------------------------------------------------------
`ifndef HANDLE_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define HANDLE_SLOT_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/hsa_pkg.sv
// ----------------------------------------------------------------------------
// hsa_pkg
// Shared sizes, codes and types of the handle slot allocator.
// ----------------------------------------------------------------------------
package hsa_pkg;

   localparam int MAX_ENTRIES = 4096;
   localparam int LAYERS      = 4;
   localparam int HANDLE_W    = $clog2(MAX_ENTRIES);
   localparam int LAYER_W     = $clog2(LAYERS);
   localparam int COUNT_W     = HANDLE_W + 1;
   localparam int MEM_AW      = LAYER_W + HANDLE_W;
   localparam int HT_W        = HANDLE_W + 1;
   localparam int HT_FREE_BIT = HANDLE_W;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;

   // Operation codes; any code other than create and destroy is a lookup.
   localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
   localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DEAD  = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_MOVE
   } state_type;

   // Per-layer bookkeeping: free-list head, live count and the number of
   // handles ever taken from the untouched tail of the initial free chain.
   typedef struct packed {
      logic [HANDLE_W-1:0] head;
      logic [COUNT_W-1:0]  count;
      logic [COUNT_W-1:0]  fill;
   } layer_state_type;

   typedef struct packed {
      logic                en;
      logic [LAYER_W-1:0]  layer;
      layer_state_type     value;
   } layer_upd_type;

endpackage

>>> rtl/hsa_ram.sv
// ----------------------------------------------------------------------------
// hsa_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module hsa_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [1 << ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/hsa_layer_regs.sv
// ----------------------------------------------------------------------------
// hsa_layer_regs
// Per-layer free-list head, live count and fill mark, one read and one update.
// ----------------------------------------------------------------------------
module hsa_layer_regs import hsa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [LAYER_W-1:0] rd_layer,
   output layer_state_type    rd_state,
   input  layer_upd_type      upd
);

   layer_state_type regs_ff [LAYERS];
   layer_state_type regs_in [LAYERS];

   always_comb begin
      for (int i = 0; i < LAYERS; i++) begin
         regs_in[i] = regs_ff[i];
      end
      if (upd.en) begin
         regs_in[upd.layer] = upd.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAYERS; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < LAYERS; i++) begin
            regs_ff[i] <= regs_in[i];
         end
      end
   end

   assign rd_state = regs_ff[rd_layer];

endmodule

>>> rtl/hsa_seq.sv
// ----------------------------------------------------------------------------
// hsa_seq
// Sequencer: reads, updates and writes back the handle and slot tables for one
// item at a time and holds the result in an output register.
// ----------------------------------------------------------------------------
module hsa_seq import hsa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // Request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [LAYER_W-1:0]  req_layer,
   input  logic [HANDLE_W-1:0] req_handle_in,
   // Result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [HANDLE_W-1:0] rsp_handle_out,
   output logic [HANDLE_W-1:0] rsp_slot,
   output logic                rsp_moved,
   output logic [HANDLE_W-1:0] rsp_move_from,
   output logic [COUNT_W-1:0]  rsp_live_count,
   // Layer bookkeeping
   output logic [LAYER_W-1:0]  lr_rd_layer,
   input  layer_state_type     lr_state,
   output layer_upd_type       lr_upd,
   // Handle table
   output logic                ht_wr_en,
   output logic [MEM_AW-1:0]   ht_wr_addr,
   output logic [HT_W-1:0]     ht_wr_data,
   output logic                ht_rd_en,
   output logic [MEM_AW-1:0]   ht_rd_addr,
   input  logic [HT_W-1:0]     ht_rd_data,
   // Slot table
   output logic                st_wr_en,
   output logic [MEM_AW-1:0]   st_wr_addr,
   output logic [HANDLE_W-1:0] st_wr_data,
   output logic                st_rd_en,
   output logic [MEM_AW-1:0]   st_rd_addr,
   input  logic [HANDLE_W-1:0] st_rd_data
);

   state_type state_ff, state_in;

   // Item registers, loaded when an item is accepted.
   logic [OP_W-1:0]     op_ff;
   logic [LAYER_W-1:0]  layer_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [HANDLE_W-1:0] head_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  fill_ff;

   // Output register.
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic [HANDLE_W-1:0] rsp_slot_ff;
   logic                rsp_moved_ff;
   logic [HANDLE_W-1:0] rsp_from_ff;
   logic [COUNT_W-1:0]  rsp_live_ff;

   logic                accept;
   logic                out_free;
   logic                is_create;
   logic                is_destroy;
   logic                layer_full;
   logic                layer_empty;
   logic [HANDLE_W-1:0] probe;
   logic                fresh;
   logic                dead;
   logic [HANDLE_W-1:0] cur_slot;
   logic [HANDLE_W-1:0] last_slot;
   logic [HANDLE_W-1:0] next_link;
   logic                need_move;
   logic                go;
   logic                rsp_load;
   logic [STATUS_W-1:0] res_status;
   logic [HANDLE_W-1:0] res_handle;
   logic [HANDLE_W-1:0] res_slot;
   logic                res_moved;
   logic [HANDLE_W-1:0] res_from;
   logic [COUNT_W-1:0]  res_live;

   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign lr_rd_layer = req_layer;

   // Decode of the item under evaluation.
   assign is_create   = (op_ff == OP_CREATE);
   assign is_destroy  = (op_ff == OP_DESTROY);
   assign layer_full  = (count_ff == COUNT_W'(MAX_ENTRIES));
   assign layer_empty = (count_ff == '0);
   assign probe       = is_create ? head_ff : handle_ff;
   // Entries at or above the fill mark were never written and still hold
   // their reset value: free, linking to the next handle.
   assign fresh       = ({1'b0, probe} >= fill_ff);
   assign dead        = fresh || ht_rd_data[HT_FREE_BIT];
   assign cur_slot    = ht_rd_data[HANDLE_W-1:0];
   assign last_slot   = count_ff[HANDLE_W-1:0] - HANDLE_W'(1);
   assign next_link   = fresh ? (head_ff + HANDLE_W'(1)) : ht_rd_data[HANDLE_W-1:0];
   assign need_move   = is_destroy && !layer_empty && !dead && (cur_slot != last_slot);
   assign go          = out_free || need_move;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (need_move) begin
               state_in = S_MOVE;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_MOVE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Memory controls, layer updates and result.
   always_comb begin
      ht_wr_en   = 1'b0;
      ht_wr_addr = {layer_ff, handle_ff};
      ht_wr_data = '0;
      ht_rd_en   = 1'b0;
      ht_rd_addr = {req_layer, (req_operation == OP_CREATE) ? lr_state.head : req_handle_in};
      st_wr_en   = 1'b0;
      st_wr_addr = {layer_ff, cur_slot};
      st_wr_data = st_rd_data;
      st_rd_en   = 1'b0;
      st_rd_addr = {layer_ff, last_slot};
      lr_upd.en            = 1'b0;
      lr_upd.layer         = layer_ff;
      lr_upd.value.head    = head_ff;
      lr_upd.value.count   = count_ff;
      lr_upd.value.fill    = fill_ff;
      rsp_load   = 1'b0;
      res_status = ST_OK;
      res_handle = '0;
      res_slot   = '0;
      res_moved  = 1'b0;
      res_from   = '0;
      res_live   = count_ff;
      case (state_ff)
         S_IDLE: begin
            ht_rd_en = accept;
         end
         S_EVAL: begin
            rsp_load = out_free && !need_move;
            if (is_create) begin
               if (layer_full) begin
                  res_status = ST_FULL;
               end else begin
                  ht_wr_en   = go;
                  ht_wr_addr = {layer_ff, head_ff};
                  ht_wr_data = {1'b0, count_ff[HANDLE_W-1:0]};
                  st_wr_en   = go;
                  st_wr_addr = {layer_ff, count_ff[HANDLE_W-1:0]};
                  st_wr_data = head_ff;
                  lr_upd.en          = go;
                  lr_upd.value.head  = next_link;
                  lr_upd.value.count = count_ff + COUNT_W'(1);
                  lr_upd.value.fill  = fresh ? (fill_ff + COUNT_W'(1)) : fill_ff;
                  res_handle = head_ff;
                  res_slot   = count_ff[HANDLE_W-1:0];
                  res_live   = count_ff + COUNT_W'(1);
               end
            end else if (layer_empty) begin
               res_status = ST_EMPTY;
            end else if (dead) begin
               res_status = ST_DEAD;
            end else if (is_destroy) begin
               // Free the handle; a move, if any, finishes in the next state.
               ht_wr_en   = go;
               ht_wr_addr = {layer_ff, handle_ff};
               ht_wr_data = {1'b1, head_ff};
               st_rd_en   = need_move;
               lr_upd.en          = go;
               lr_upd.value.head  = handle_ff;
               lr_upd.value.count = count_ff - COUNT_W'(1);
               res_slot   = cur_slot;
               res_live   = count_ff - COUNT_W'(1);
            end else begin
               res_slot = cur_slot;
            end
         end
         S_MOVE: begin
            // The owner of the last slot takes over the hole.
            rsp_load   = out_free;
            st_wr_en   = out_free;
            st_wr_addr = {layer_ff, cur_slot};
            st_wr_data = st_rd_data;
            ht_wr_en   = out_free;
            ht_wr_addr = {layer_ff, st_rd_data};
            ht_wr_data = {1'b0, cur_slot};
            res_slot   = cur_slot;
            res_moved  = 1'b1;
            res_from   = last_slot;
            res_live   = {1'b0, last_slot};
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_operation;
         layer_ff  <= req_layer;
         handle_ff <= req_handle_in;
         head_ff   <= lr_state.head;
         count_ff  <= lr_state.count;
         fill_ff   <= lr_state.fill;
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status;
         rsp_handle_ff <= res_handle;
         rsp_slot_ff   <= res_slot;
         rsp_moved_ff  <= res_moved;
         rsp_from_ff   <= res_from;
         rsp_live_ff   <= res_live;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_moved      = rsp_moved_ff;
   assign rsp_move_from  = rsp_from_ff;
   assign rsp_live_count = rsp_live_ff;

endmodule

>>> rtl/handle_slot_allocator_top.sv
// Results: a create, a lookup, an error or a destroy of the last slot is
// answered from the eval state, a destroy that moves a slot from the move state.
// The block takes no new item until the sequencer is back in idle, and it
// holds in eval or move while the output register is stalled.
// Reset: synchronous and active high; it clears the sequencer, the output valid
// and every layer's head, live count and fill mark, and needs no clearing pass.
// ----------------------------------------------------------------------------
// handle_slot_allocator_top
// Per-layer slot map: stable handles over a dense slot array, with a free list.
// ----------------------------------------------------------------------------
`include "handle_slot_allocator_top_macros.svh"

module handle_slot_allocator_top import hsa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [LAYER_W-1:0]  req_layer,
   input  logic [HANDLE_W-1:0] req_handle_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [HANDLE_W-1:0] rsp_handle_out,
   output logic [HANDLE_W-1:0] rsp_slot,
   output logic                rsp_moved,
   output logic [HANDLE_W-1:0] rsp_move_from,
   output logic [COUNT_W-1:0]  rsp_live_count
);

   // The handle table holds, for every layer and handle, either the dense slot
   // of a live handle or a free mark in the top bit with the link to the next
   // free handle below it. The slot table holds the owning handle of every
   // dense slot. Both are single memories addressed by layer and index.
   //
   // The reset image of the handle table is a chain where every handle links
   // to the next one. Instead of writing that image, each layer keeps a fill
   // mark: the number of handles ever taken from the fresh end of the chain.
   // Handles are first handed out in ascending order, so every entry at or
   // above the fill mark is still untouched and is treated as its reset value.
   // The free list always has exactly as many links as the layer has free
   // handles, so a layer is full exactly when its live count reaches the
   // capacity and the end-of-chain link is never needed.
   //
   // An item is handled in these steps:
   //   accept - the handle table is read at the free head (create) or at the
   //            given handle (destroy, lookup), and the layer state is copied;
   //   eval   - the entry is checked; a create binds the head to the next dense
   //            slot and pops the list; a destroy pushes the handle back on the
   //            list and, when the hole is not the last slot, reads the owner
   //            of the last slot;
   //   move   - the owner of the last slot is bound to the hole in both tables.
   // Results wait in an output register; the sequencer holds in eval or move
   // while an earlier item is still stalled there.

   logic [LAYER_W-1:0]  lr_rd_layer;
   layer_state_type     lr_state;
   layer_upd_type       lr_upd;

   logic                ht_wr_en;
   logic [MEM_AW-1:0]   ht_wr_addr;
   logic [HT_W-1:0]     ht_wr_data;
   logic                ht_rd_en;
   logic [MEM_AW-1:0]   ht_rd_addr;
   logic [HT_W-1:0]     ht_rd_data;

   logic                st_wr_en;
   logic [MEM_AW-1:0]   st_wr_addr;
   logic [HANDLE_W-1:0] st_wr_data;
   logic                st_rd_en;
   logic [MEM_AW-1:0]   st_rd_addr;
   logic [HANDLE_W-1:0] st_rd_data;

   // Handle table: free mark and link, or dense slot, per layer and handle.
   hsa_ram #(
      .DATA_W (HT_W),
      .ADDR_W (MEM_AW)
   ) u_handle_table (
      .clock   (clock),
      .wr_en   (ht_wr_en),
      .wr_addr (ht_wr_addr),
      .wr_data (ht_wr_data),
      .rd_en   (ht_rd_en),
      .rd_addr (ht_rd_addr),
      .rd_data (ht_rd_data)
   );

   // Slot table: owning handle per layer and dense slot. It is only read
   // below the live count, where every entry has been written.
   hsa_ram #(
      .DATA_W (HANDLE_W),
      .ADDR_W (MEM_AW)
   ) u_slot_table (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   hsa_layer_regs u_layer_regs (
      .clock    (clock),
      .reset    (reset),
      .rd_layer (lr_rd_layer),
      .rd_state (lr_state),
      .upd      (lr_upd)
   );

   hsa_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_layer      (req_layer),
      .req_handle_in  (req_handle_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_handle_out (rsp_handle_out),
      .rsp_slot       (rsp_slot),
      .rsp_moved      (rsp_moved),
      .rsp_move_from  (rsp_move_from),
      .rsp_live_count (rsp_live_count),
      .lr_rd_layer    (lr_rd_layer),
      .lr_state       (lr_state),
      .lr_upd         (lr_upd),
      .ht_wr_en       (ht_wr_en),
      .ht_wr_addr     (ht_wr_addr),
      .ht_wr_data     (ht_wr_data),
      .ht_rd_en       (ht_rd_en),
      .ht_rd_addr     (ht_rd_addr),
      .ht_rd_data     (ht_rd_data),
      .st_wr_en       (st_wr_en),
      .st_wr_addr     (st_wr_addr),
      .st_wr_data     (st_wr_data),
      .st_rd_en       (st_rd_en),
      .st_rd_addr     (st_rd_addr),
      .st_rd_data     (st_rd_data)
   );

   // Only one item is in the tables at a time.
   `HSA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall,
      req_stall, "item accepted while another is in work")

   // A move always copies from the old last slot, which is the new live count.
   `HSA_ASSERT_SAME(a_move_from_last, clock, reset, rsp_valid && rsp_moved,
      (rsp_status == ST_OK) && (rsp_live_count[HANDLE_W] == 1'b0)
      && (rsp_move_from == rsp_live_count[HANDLE_W-1:0]) && (rsp_slot != rsp_move_from),
      "move result inconsistent with live count")

   // The live count never exceeds the layer capacity.
   `HSA_ASSERT_SAME(a_live_bound, clock, reset, rsp_valid,
      rsp_live_count <= COUNT_W'(MAX_ENTRIES), "live count beyond capacity")

endmodule

>>> sim/slot_map_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slot map checker
// Watches both channels of the handle slot allocator. It predicts the result
// of every accepted item from its own copy of the handle and slot tables and
// compares each result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module slot_map_checker import hsa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [LAYER_W-1:0]  req_layer,
   input  logic [HANDLE_W-1:0] req_handle_in,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [HANDLE_W-1:0] rsp_handle_out,
   input  logic [HANDLE_W-1:0] rsp_slot,
   input  logic                rsp_moved,
   input  logic [HANDLE_W-1:0] rsp_move_from,
   input  logic [COUNT_W-1:0]  rsp_live_count,
   output int                  mismatches,
   output int                  outstanding,
   output int                  checked,
   output int                  relocations,
   output int                  refusals
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle_out;
      logic [HANDLE_W-1:0] slot;
      logic                moved;
      logic [HANDLE_W-1:0] move_from;
      logic [COUNT_W-1:0]  live_count;
   } slot_answer_type;

   // A free entry links to the next free handle (MAX_ENTRIES ends the chain);
   // a live entry holds its dense slot.
   typedef struct packed {
      logic               is_free;
      logic [COUNT_W-1:0] link;
   } handle_entry_type;

   handle_entry_type    handle_map [LAYERS][MAX_ENTRIES];
   logic [HANDLE_W-1:0] slot_owner [LAYERS][MAX_ENTRIES];
   logic [COUNT_W-1:0]  free_head  [LAYERS];
   logic [COUNT_W-1:0]  live_total [LAYERS];
   slot_answer_type     answer_fifo [$];

   function automatic void clear_tables();
      for (int l = 0; l < LAYERS; l++) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            handle_map[l][i].is_free = 1'b1;
            handle_map[l][i].link    = COUNT_W'(i + 1);
         end
         free_head[l]  = '0;
         live_total[l] = '0;
      end
   endfunction

   function automatic slot_answer_type apply_slot_operation(
      input logic [OP_W-1:0]     op,
      input logic [LAYER_W-1:0]  layer,
      input logic [HANDLE_W-1:0] handle
   );
      slot_answer_type     ans;
      logic [COUNT_W-1:0]  cnt;
      logic [COUNT_W-1:0]  head;
      logic [COUNT_W-1:0]  last;
      logic [COUNT_W-1:0]  pos;
      logic [HANDLE_W-1:0] owner;
      ans  = '0;
      cnt  = live_total[layer];
      head = free_head[layer];
      if (op == OP_CREATE) begin
         if (cnt >= MAX_ENTRIES || head >= MAX_ENTRIES) begin
            ans.status = ST_FULL;
         end else begin
            free_head[layer] = handle_map[layer][head[HANDLE_W-1:0]].link;
            handle_map[layer][head[HANDLE_W-1:0]].is_free = 1'b0;
            handle_map[layer][head[HANDLE_W-1:0]].link    = cnt;
            slot_owner[layer][cnt[HANDLE_W-1:0]]          = head[HANDLE_W-1:0];
            ans.handle_out    = head[HANDLE_W-1:0];
            ans.slot          = cnt[HANDLE_W-1:0];
            live_total[layer] = cnt + 1'b1;
         end
      end else if (cnt == 0) begin
         ans.status = ST_EMPTY;
      end else if (handle_map[layer][handle].is_free) begin
         ans.status = ST_DEAD;
      end else begin
         pos      = handle_map[layer][handle].link;
         ans.slot = pos[HANDLE_W-1:0];
         if (op == OP_DESTROY) begin
            last = cnt - 1'b1;
            handle_map[layer][handle].is_free = 1'b1;
            handle_map[layer][handle].link    = head;
            free_head[layer]  = COUNT_W'(handle);
            live_total[layer] = last;
            // The last live slot fills the hole unless the hole is the last slot.
            if (pos != last) begin
               owner = slot_owner[layer][last[HANDLE_W-1:0]];
               slot_owner[layer][pos[HANDLE_W-1:0]] = owner;
               handle_map[layer][owner].link = pos;
               ans.moved     = 1'b1;
               ans.move_from = last[HANDLE_W-1:0];
            end
         end
      end
      ans.live_count = live_total[layer];
      return ans;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      slot_answer_type want;
      if (reset) begin
         clear_tables();
         answer_fifo.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answer_fifo.size() == 0) begin
               $error("result arrived with no item outstanding");
               mismatches++;
            end else begin
               want = answer_fifo.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("handle_out", want.handle_out, rsp_handle_out);
               check_field("slot", want.slot, rsp_slot);
               check_field("moved", want.moved, rsp_moved);
               check_field("move_from", want.move_from, rsp_move_from);
               check_field("live_count", want.live_count, rsp_live_count);
               checked++;
               if (want.moved) relocations++;
               if (want.status != ST_OK) refusals++;
            end
         end
         if (req_valid && !req_stall)
            answer_fifo.push_back(apply_slot_operation(req_operation, req_layer,
                                                       req_handle_in));
      end
      outstanding = answer_fifo.size();
   end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Handle slot allocator testbench
// Drives directed and random create, destroy and lookup items with bursty
// input and a randomly stalling receiver that also holds off for one long
// stretch, and leaves all checking to the slot map checker.
// ----------------------------------------------------------------------------
module tb_top;
   import hsa_pkg::*;

   // Codes 2 and 3 both look up a handle; the spare code is tested on its own.
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
   localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;
   localparam logic [LAYER_W-1:0] FILL_LAYER = 2'd3;
   localparam int RANDOM_ITEMS = 1500;
   localparam int HOLD_CYCLES  = 500;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [LAYER_W-1:0]  layer;
      logic [HANDLE_W-1:0] handle;
   } sent_item_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation = '0;
   logic [LAYER_W-1:0]  req_layer = '0;
   logic [HANDLE_W-1:0] req_handle_in = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [HANDLE_W-1:0] rsp_handle_out;
   logic [HANDLE_W-1:0] rsp_slot;
   logic                rsp_moved;
   logic [HANDLE_W-1:0] rsp_move_from;
   logic [COUNT_W-1:0]  rsp_live_count;

   int mismatches;
   int outstanding;
   int checked;
   int relocations;
   int refusals;

   int items_sent = 0;
   int burst_left = 0;
   bit hold_request = 1'b0;

   // Items in flight, in acceptance order, and the {layer, handle} pairs that
   // the block has reported live. The pool only steers the stimulus toward
   // live handles; correctness is judged by the checker alone.
   sent_item_type                     in_flight [$];
   logic [LAYER_W+HANDLE_W-1:0]       known_live [$];

   handle_slot_allocator_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_layer      (req_layer),
      .req_handle_in  (req_handle_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_handle_out (rsp_handle_out),
      .rsp_slot       (rsp_slot),
      .rsp_moved      (rsp_moved),
      .rsp_move_from  (rsp_move_from),
      .rsp_live_count (rsp_live_count)
   );

   slot_map_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_layer      (req_layer),
      .req_handle_in  (req_handle_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_handle_out (rsp_handle_out),
      .rsp_slot       (rsp_slot),
      .rsp_moved      (rsp_moved),
      .rsp_move_from  (rsp_move_from),
      .rsp_live_count (rsp_live_count),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .checked        (checked),
      .relocations    (relocations),
      .refusals       (refusals)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // The slowest legal run is far below this; reaching it means the block hung.
   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   // Receiver: stretches of random length, each with its own stall density,
   // from never stalling to stalling most cycles. When the stimulus asks for
   // it, the receiver refuses results for a long stretch so that the block
   // backs up and has to stall its input.
   initial begin : receiver
      int stretch;
      int density;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            for (int c = 0; c < HOLD_CYCLES; c++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         stretch = $urandom_range(20, 200);
         case ($urandom_range(0, 2))
            0: density = 0;
            1: density = 25;
            default: density = 75;
         endcase
         for (int c = 0; c < stretch; c++) begin
            rsp_stall <= ($urandom_range(0, 99) < density);
            @(posedge clock);
         end
      end
   end

   // Track the live handles from the results. A successful create adds the
   // handle it returned; a successful destroy removes the handle it named.
   always @(posedge clock) begin : live_tracker
      sent_item_type done;
      logic [LAYER_W+HANDLE_W-1:0] key;
      if (!reset && rsp_valid && !rsp_stall && in_flight.size() != 0) begin
         done = in_flight.pop_front();
         if (rsp_status == ST_OK && done.op == OP_CREATE) begin
            known_live.push_back({done.layer, rsp_handle_out});
         end else if (rsp_status == ST_OK && done.op == OP_DESTROY) begin
            key = {done.layer, done.handle};
            for (int i = 0; i < known_live.size(); i++) begin
               if (known_live[i] == key) begin
                  known_live.delete(i);
                  break;
               end
            end
         end
      end
      if (!reset && req_valid && !req_stall)
         in_flight.push_back('{op: req_operation, layer: req_layer, handle: req_handle_in});
   end

   // Offer one item and wait until it is taken. The sender works in bursts;
   // at the end of each burst it drops valid for a random gap. A zero gap
   // keeps valid high, so valid is never lowered and raised in one step.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [LAYER_W-1:0] lyr,
                            input logic [HANDLE_W-1:0] hnd);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_layer     <= lyr;
      req_handle_in <= hnd;
      do @(posedge clock); while (req_stall);
      burst_left--;
      items_sent++;
   endtask

   // One random item. Destroys and lookups mostly name a handle that is
   // known to be live, so that they reach the slot moves; the rest name any
   // handle at all. The second half leans toward destroys to drain layers.
   task automatic send_random_item(input bit draining);
      int roll;
      int pick;
      logic [OP_W-1:0] op;
      logic [LAYER_W-1:0] lyr;
      logic [HANDLE_W-1:0] hnd;
      roll = $urandom_range(0, 99);
      lyr  = LAYER_W'($urandom_range(0, LAYERS - 1));
      hnd  = HANDLE_W'($urandom);
      if (roll < (draining ? 20 : 40))
         op = OP_CREATE;
      else if (roll < 70)
         op = OP_DESTROY;
      else if (roll < 92)
         op = OP_LOOKUP;
      else
         op = OP_SPARE;
      if (op != OP_CREATE) begin
         if (known_live.size() != 0 && $urandom_range(0, 99) < 80) begin
            pick = $urandom_range(0, known_live.size() - 1);
            {lyr, hnd} = known_live[pick];
         end else if ($urandom_range(0, 1) == 0) begin
            hnd = HANDLE_W'($urandom_range(0, 15));
         end
      end
      send_item(op, lyr, hnd);
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Every layer starts empty with handles handed out in
      // order, so layer 0 below gets handles 0, 1 and 2 in slots 0, 1 and 2.
      send_item(OP_LOOKUP, 2'd0, 12'd0);        // lookup on an empty layer
      send_item(OP_DESTROY, 2'd0, 12'hFFF);     // destroy on an empty layer
      send_item(OP_SPARE, 2'd0, 12'd0);         // spare code on an empty layer
      send_item(OP_CREATE, 2'd0, 12'hFFF);      // handle field is ignored
      send_item(OP_CREATE, 2'd0, 12'd0);
      send_item(OP_CREATE, 2'd0, 12'hAAA);
      send_item(OP_LOOKUP, 2'd0, 12'd1);
      send_item(OP_SPARE, 2'd0, 12'd2);         // spare code acts as lookup
      send_item(OP_LOOKUP, 2'd0, 12'hFFF);      // never allocated, so not live
      send_item(OP_LOOKUP, 2'd0, 12'd3);
      send_item(OP_DESTROY, 2'd0, 12'd0);       // hole at slot 0, slot 2 moves in
      send_item(OP_DESTROY, 2'd0, 12'd0);       // freed handle reads back dead
      send_item(OP_DESTROY, 2'd0, 12'd1);       // last slot, nothing moves
      send_item(OP_LOOKUP, 2'd0, 12'd2);        // now sits in slot 0
      send_item(OP_CREATE, 2'd0, 12'h555);      // reuses the latest freed handle
      send_item(OP_DESTROY, 2'd0, 12'd2);
      send_item(OP_DESTROY, 2'd0, 12'd1);       // layer back to empty
      send_item(OP_LOOKUP, 2'd0, 12'd1);
      send_item(OP_CREATE, 2'd1, 12'd0);
      send_item(OP_CREATE, 2'd2, 12'd0);
      send_item(OP_CREATE, FILL_LAYER, 12'd0);

      // The receiver holds off for a long stretch while random items keep
      // coming, so the block backs up and has to stall its input.
      hold_request = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS; i++)
         send_random_item(i >= RANDOM_ITEMS / 2);
      req_valid <= 1'b0;

      // Let the last accepted item be counted, then wait for every result and
      // keep watching so that a stray result would show.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d items; %0d results checked, %0d with a slot move, %0d refused.",
               items_sent, checked, relocations, refusals);
      $display("Covered empty-layer, dead-handle and spare-code items, slot moves and a long hold.");
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
